// File: rtl/mf3rgb_pkg.sv
// types, constants and compare-network functions for the 3x3 rgb median filter
package mf3rgb_pkg;

    localparam int unsigned SMP_W      = 8;
    localparam int unsigned FW_W       = 11;
    localparam int unsigned FH_W       = 13;
    localparam int unsigned ROW_W      = 13;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned FW_RESET   = 768;
    localparam int unsigned FH_RESET   = 512;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [SMP_W-1:0] t_smp;

    // one pixel, red in the lowest bits
    typedef struct packed {
        t_smp b;
        t_smp g;
        t_smp r;
    } t_pix;

    // three samples of one channel, sorted
    typedef struct packed {
        t_smp hi;
        t_smp mi;
        t_smp lo;
    } t_trip;

    // one window column, each channel sorted on its own
    typedef struct packed {
        t_trip b;
        t_trip g;
        t_trip r;
    } t_col;

    function automatic t_smp smin(input t_smp a, input t_smp b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_smp smax(input t_smp a, input t_smp b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_smp med3(input t_smp a, input t_smp b, input t_smp c);
        return smax(smin(a, b), smin(smax(a, b), c));
    endfunction

    function automatic t_trip sort3(input t_smp a, input t_smp b, input t_smp c);
        t_trip t;
        t.lo = smin(smin(a, b), c);
        t.hi = smax(smax(a, b), c);
        t.mi = med3(a, b, c);
        return t;
    endfunction

    function automatic t_col col_sort(input t_pix top, input t_pix mid, input t_pix bot);
        t_col c;
        c.r = sort3(top.r, mid.r, bot.r);
        c.g = sort3(top.g, mid.g, bot.g);
        c.b = sort3(top.b, mid.b, bot.b);
        return c;
    endfunction

    // median of nine from three sorted columns
    function automatic t_smp med9(input t_trip x, input t_trip y, input t_trip z);
        t_smp lo;
        t_smp mi;
        t_smp hi;
        lo = smax(smax(x.lo, y.lo), z.lo);
        mi = med3(x.mi, y.mi, z.mi);
        hi = smin(smin(x.hi, y.hi), z.hi);
        return med3(lo, mi, hi);
    endfunction

endpackage

// File: rtl/median_filter_3x3_rgb_unit.sv
// streaming 3x3 median filter over rgb pixels with edge replication
//
// usage
//   s_axis carries one item per transfer: tuser = cmd (0 pixel, 1 drain item),
//   tdata = red/green/blue. a frame is frame_height rows of frame_width pixels
//   in raster order, followed by frame_width+1 drain items.
//   m_axis carries the per-channel medians; tlast marks the final pixel of the frame.
//   the filtered output for a pixel follows its input by frame_width+1 items.
//   items of the wrong kind (drain while pixels are expected or the other way
//   round) are dropped without effect.
// timing
//   one item per clock sustained while s_axis_tready is high; the result of a
//   transfer passes the row store read, column sort and median tree stages.
//   the row stores have one read and one write port each, which sets the rate
//   at one item per cycle.
// reset and stall
//   i_rst_n (synchronous, low) clears position counters, window and pipeline;
//   frame_width/frame_height return to 768/512. a config write restarts the frame.
//   when m_axis stalls, one extra result is held in a skid register and
//   s_axis_tready drops only once that register is full.
module median_filter_3x3_rgb_unit #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [mf3rgb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mf3rgb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [23:0]                          s_axis_tdata,   // in_red, in_green, in_blue
    input  logic                                 s_axis_tuser,   // cmd
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [23:0]                          m_axis_tdata,   // out_red, out_green, out_blue
    output logic                                 m_axis_tlast    // frame_last
);

    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned WCMP_W = (WEFF_W > mf3rgb_pkg::FW_W) ? WEFF_W : mf3rgb_pkg::FW_W;
    localparam int unsigned ROW_W  = mf3rgb_pkg::ROW_W;

    // item leaving the row store read stage
    typedef struct packed {
        logic                  valid;
        logic                  fin;      // final drain item, no column shift
        logic                  pre;      // emits last pixel of an earlier row before the shift
        logic                  post;     // emits the pixel left of the new column
        logic                  c_is1;
        logic                  w_is1;
        logic                  row_ge1;
        logic                  row_ge2;
        logic                  wr;       // pixel item, row stores get written
        logic                  last;
        logic [COL_W-1:0]      col;
        mf3rgb_pkg::t_pix      pix;
        logic                  fwd;      // store read hit the previous item's write
        mf3rgb_pkg::t_pix      fwd_new;
        mf3rgb_pkg::t_pix      fwd_old;
    } t_s1;

    // selected window columns for the median tree
    typedef struct packed {
        logic                  valid;
        logic                  last;
        mf3rgb_pkg::t_col      ca;
        mf3rgb_pkg::t_col      cb;
        mf3rgb_pkg::t_col      cc;
    } t_s2;

    // configuration registers
    logic [mf3rgb_pkg::FW_W-1:0] r_frame_width;
    logic [mf3rgb_pkg::FH_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mf3rgb_pkg::FW_W'(mf3rgb_pkg::FW_RESET);
            r_frame_height <= mf3rgb_pkg::FH_W'(mf3rgb_pkg::FH_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mf3rgb_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[mf3rgb_pkg::FW_W-1:0];
                mf3rgb_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[mf3rgb_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped frame size: last column index, last row index, row count
    logic [WCMP_W-1:0] fw_ext;
    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;
    logic [ROW_W-1:0]  h_eff;

    assign fw_ext = WCMP_W'(r_frame_width);

    always_comb begin
        if (fw_ext == '0) begin
            w_last = '0;
        end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(fw_ext - WCMP_W'(1));
        end
        if (r_frame_height == '0) begin
            h_last = '0;
        end else if (r_frame_height > ROW_W'(mf3rgb_pkg::MAX_HEIGHT)) begin
            h_last = ROW_W'(mf3rgb_pkg::MAX_HEIGHT - 1);
        end else begin
            h_last = r_frame_height - ROW_W'(1);
        end
        h_eff = h_last + ROW_W'(1);
    end

    // pipeline enable: everything advances unless the skid register is full
    logic r_skid_valid;
    logic en;
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    // position counters
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    logic acc, take, expect_drain, is_final, c_zero, row_ge1, row_ge2;
    logic pre, post, emit, col_last, frame_last;

    assign acc          = s_axis_tvalid && s_axis_tready;
    assign expect_drain = r_in_row > h_last;
    assign is_final     = r_in_row > h_eff;
    // wrong item kinds are dropped here
    assign take         = acc && ((s_axis_tuser == mf3rgb_pkg::CMD_DRAIN) == expect_drain);
    assign c_zero       = r_in_col == '0;
    assign row_ge1      = r_in_row != '0;
    assign row_ge2      = r_in_row > ROW_W'(1);
    assign pre          = !is_final && c_zero && row_ge2;
    assign post         = !is_final && !c_zero && row_ge1;
    assign emit         = is_final || pre || post;
    assign col_last     = r_in_col == w_last;
    assign frame_last   = (r_out_row == h_last) && (r_out_col == w_last);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_we || (take && is_final)) begin
            // frame restart
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (take) begin
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (emit) begin
                if (r_out_col == w_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // row stores: newer holds the row above, older the row above that
    mf3rgb_pkg::t_pix r_mem_new [MAX_WIDTH];
    mf3rgb_pkg::t_pix r_mem_old [MAX_WIDTH];
    mf3rgb_pkg::t_pix r_rd_new;
    mf3rgb_pkg::t_pix r_rd_old;

    t_s1              r_s1, n_s1;
    mf3rgb_pkg::t_pix new_eff;
    mf3rgb_pkg::t_pix old_eff;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_new <= r_mem_new[r_in_col];
            r_rd_old <= r_mem_old[r_in_col];
        end
        if (en && r_s1.valid && r_s1.wr) begin
            r_mem_new[r_s1.col] <= r_s1.pix;
            r_mem_old[r_s1.col] <= new_eff;
        end
    end

    always_comb begin
        n_s1.valid   = take;
        n_s1.fin     = is_final;
        n_s1.pre     = pre;
        n_s1.post    = post;
        n_s1.c_is1   = r_in_col == COL_W'(1);
        n_s1.w_is1   = w_last == '0;
        n_s1.row_ge1 = row_ge1;
        n_s1.row_ge2 = row_ge2;
        n_s1.wr      = !expect_drain;
        n_s1.last    = frame_last;
        n_s1.col     = r_in_col;
        n_s1.pix     = mf3rgb_pkg::t_pix'(s_axis_tdata);
        // single-column frames read the entry the item ahead is writing
        n_s1.fwd     = r_s1.valid && r_s1.wr && (r_s1.col == r_in_col);
        n_s1.fwd_new = r_s1.pix;
        n_s1.fwd_old = new_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (en) begin
            r_s1 <= n_s1;
        end
    end

    // new column with vertical edge replication, sorted per channel
    mf3rgb_pkg::t_pix top, mid, bot;
    mf3rgb_pkg::t_col new_col;

    assign new_eff = r_s1.fwd ? r_s1.fwd_new : r_rd_new;
    assign old_eff = r_s1.fwd ? r_s1.fwd_old : r_rd_old;
    assign mid     = r_s1.row_ge1 ? new_eff : r_s1.pix;
    assign top     = r_s1.row_ge2 ? old_eff : mid;
    assign bot     = r_s1.wr ? r_s1.pix : mid;
    assign new_col = mf3rgb_pkg::col_sort(top, mid, bot);

    // window of sorted columns, left to right
    mf3rgb_pkg::t_col r_win_l, r_win_m, r_win_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_l <= '0;
            r_win_m <= '0;
            r_win_r <= '0;
        end else if (en && r_s1.valid && !r_s1.fin) begin
            r_win_l <= r_win_m;
            r_win_m <= r_win_r;
            r_win_r <= new_col;
        end
    end

    // column selection with horizontal edge replication
    t_s2 r_s2, n_s2;

    always_comb begin
        n_s2.valid = r_s1.valid && (r_s1.fin || r_s1.pre || r_s1.post);
        n_s2.last  = r_s1.last;
        if (r_s1.post) begin
            // window after the shift: left edge pixel repeats its own column
            n_s2.ca = r_s1.c_is1 ? r_win_r : r_win_m;
            n_s2.cb = r_win_r;
            n_s2.cc = new_col;
        end else begin
            // right edge of a row: rightmost column repeats
            n_s2.ca = r_s1.w_is1 ? r_win_r : r_win_m;
            n_s2.cb = r_win_r;
            n_s2.cc = r_win_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (en) begin
            r_s2 <= n_s2;
        end
    end

    // median tree
    mf3rgb_pkg::t_pix res;

    assign res.r = mf3rgb_pkg::med9(r_s2.ca.r, r_s2.cb.r, r_s2.cc.r);
    assign res.g = mf3rgb_pkg::med9(r_s2.ca.g, r_s2.cb.g, r_s2.cc.g);
    assign res.b = mf3rgb_pkg::med9(r_s2.ca.b, r_s2.cb.b, r_s2.cc.b);

    // output register plus skid register
    logic             r_out_valid;
    mf3rgb_pkg::t_pix r_out_pix;
    logic             r_out_last;
    mf3rgb_pkg::t_pix r_skid_pix;
    logic             r_skid_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !m_axis_tready) begin
            if (en && r_s2.valid) begin
                r_skid_valid <= 1'b1;
                r_skid_pix   <= res;
                r_skid_last  <= r_s2.last;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_out_pix    <= r_skid_pix;
            r_out_last   <= r_skid_last;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s2.valid;
            r_out_pix   <= res;
            r_out_last  <= r_s2.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid register filled without a stalled output");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_col <= w_last) && (r_out_col <= w_last))
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= (h_eff + ROW_W'(1)))
        else $error("input row counter beyond last drain row");
`endif

endmodule
